@@ hdl/decimal_date_time_to_epoch_macros.svh @@
// assertion helpers shared by the rtl
`ifndef DECIMAL_DATE_TIME_TO_EPOCH_MACROS_SVH
`define DECIMAL_DATE_TIME_TO_EPOCH_MACROS_SVH

// property that must hold at every edge outside reset
`define DTTE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// overlapping implication outside reset
`define DTTE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/dtte_pkg.sv @@
`default_nettype none

package dtte_pkg;

    localparam int C_DATE_W  = 28;
    localparam int C_TIME_W  = 21;
    localparam int C_ZONE_W  = 5;
    localparam int C_EPOCH_W = 40;

    // magnitude bits of the legal inputs
    localparam int C_DATE_MAG_W = C_DATE_W - 1;
    localparam int C_TIME_MAG_W = C_TIME_W - 1;

    // widths of the split fields and the intermediate sums
    localparam int C_DIG_W     = 7;
    localparam int C_YMD_Q_W   = 20;
    localparam int C_HMS_Q_W   = 14;
    localparam int C_YEAR_W    = 14;
    localparam int C_YRS_W     = 15;
    localparam int C_LEAPS_W   = 13;
    localparam int C_BASE_W    = 13;
    localparam int C_MDAYS_W   = 9;
    localparam int C_DAYS_W    = 23;
    localparam int C_TODS_W    = 20;
    localparam int C_HOURZ_W   = 8;

    localparam int C_RADIX        = 100;
    localparam int C_EPOCH_YEAR   = 1970;
    localparam int C_DAYS_PER_YR  = 365;
    localparam int C_SEC_PER_DAY  = 86400;
    localparam int C_SEC_PER_HOUR = 3600;
    localparam int C_SEC_PER_MIN  = 60;
    localparam int C_MONTHS       = 12;
    localparam int C_HOURS        = 24;
    localparam int C_MINUTES      = 60;
    localparam int C_SEC_LIMIT    = 60;

    // days before the start of each month, index = whole months elapsed
    localparam logic [C_MDAYS_W-1:0] C_CUM_NORMAL [C_MONTHS+1] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [C_MDAYS_W-1:0] C_CUM_LEAP [C_MONTHS+1] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    typedef struct packed {
        logic valid;
        logic illegal;
    } t_ctl;

    // days of the whole months before the given month, capped at a full year
    function automatic logic [C_MDAYS_W-1:0] f_month_days(input logic [C_DIG_W-1:0] month,
                                                          input logic leap);
        logic [3:0] idx;
        if (month == '0) begin
            idx = 4'd0;
        end else if (month > C_DIG_W'(C_MONTHS + 1)) begin
            idx = 4'(C_MONTHS);
        end else begin
            idx = 4'(month - C_DIG_W'(1));
        end
        return leap ? C_CUM_LEAP[idx] : C_CUM_NORMAL[idx];
    endfunction

endpackage

`default_nettype wire

@@ hdl/dtte_div100.sv @@
`default_nettype none

module dtte_div100 import dtte_pkg::*; #(
    parameter int W = 20
) (
    input  logic               i_clk,
    input  logic [W-1:0]       i_x,
    output logic [W-1:0]       o_quot,
    output logic [C_DIG_W-1:0] o_rem
);

    // reciprocal scaled so the estimate is the quotient or one below it
    localparam int K = W + 7;
    localparam logic [W:0] M = (W+1)'((64'd1 << K) / C_RADIX);

    logic [W-1:0] r_x;
    logic [2*W:0] r_prod;
    logic [W-1:0] r_quot;
    logic [C_DIG_W-1:0] r_rem;

    logic [W-1:0] w_q0;
    logic [W-1:0] w_r0;
    logic         w_fix;
    logic [W-1:0] n_quot;
    logic [C_DIG_W-1:0] n_rem;

    always_ff @(posedge i_clk) begin
        r_x    <= i_x;
        r_prod <= (2*W+1)'(i_x) * (2*W+1)'(M);
    end

    always_comb begin
        w_q0  = W'(r_prod[2*W:K]);
        w_r0  = r_x - w_q0 * W'(C_RADIX);
        w_fix = (w_r0 >= W'(C_RADIX));
        if (w_fix) begin
            n_quot = w_q0 + W'(1);
            n_rem  = C_DIG_W'(w_r0 - W'(C_RADIX));
        end else begin
            n_quot = w_q0;
            n_rem  = C_DIG_W'(w_r0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ hdl/dtte_cal.sv @@
`default_nettype none
`include "decimal_date_time_to_epoch_macros.svh"

module dtte_cal import dtte_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctl                       i_ctl,
    input  logic [C_YEAR_W-1:0]        i_year,
    input  logic [C_DIG_W-1:0]         i_month,
    input  logic [C_DIG_W-1:0]         i_mday,
    input  logic [C_DIG_W-1:0]         i_hour,
    input  logic [C_DIG_W-1:0]         i_min,
    input  logic [C_DIG_W-1:0]         i_sec,
    output t_ctl                       o_ctl,
    output logic                       o_out_of_range,
    output logic signed [C_YRS_W-1:0]  o_yrs,
    output logic signed [C_BASE_W-1:0] o_base,
    output logic [C_DIG_W-1:0]         o_hour,
    output logic [C_DIG_W-1:0]         o_min,
    output logic [C_DIG_W-1:0]         o_sec
);

    t_ctl                       r_ctl;
    logic                       r_oor;
    logic signed [C_YRS_W-1:0]  r_yrs;
    logic signed [C_BASE_W-1:0] r_base;
    logic [C_DIG_W-1:0]         r_hour;
    logic [C_DIG_W-1:0]         r_min;
    logic [C_DIG_W-1:0]         r_sec;

    logic signed [C_YRS_W-1:0]   n_yrs;
    logic signed [C_YRS_W-1:0]   w_q;
    logic signed [C_LEAPS_W-1:0] w_leaps;
    logic                        w_leap;
    logic [C_MDAYS_W-1:0]        w_mdays;
    logic signed [C_BASE_W-1:0]  n_base;
    logic                        n_oor;

    always_comb begin
        n_yrs   = $signed({1'b0, i_year}) - C_YRS_W'(C_EPOCH_YEAR);
        // year 1968 is the leap year just before the epoch
        w_q     = n_yrs + C_YRS_W'(2);
        w_leaps = C_LEAPS_W'(w_q >>> 2);
        w_leap  = (w_q[1:0] == 2'b00);
        // a leap year's own day falls inside the month table
        if (w_leap) begin
            w_leaps = w_leaps - C_LEAPS_W'(1);
        end
        w_mdays = f_month_days(i_month, w_leap);
        n_base  = $signed(C_BASE_W'(w_mdays)) + $signed(C_BASE_W'(i_mday))
                - C_BASE_W'(1) + C_BASE_W'(w_leaps);
        n_oor   = !i_ctl.illegal
                && (i_sec > C_DIG_W'(C_SEC_LIMIT) || i_min >= C_DIG_W'(C_MINUTES)
                    || i_hour >= C_DIG_W'(C_HOURS) || i_month > C_DIG_W'(C_MONTHS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oor  <= n_oor;
        r_yrs  <= n_yrs;
        r_base <= n_base;
        r_hour <= i_hour;
        r_min  <= i_min;
        r_sec  <= i_sec;
    end

    assign o_ctl          = r_ctl;
    assign o_out_of_range = r_oor;
    assign o_yrs          = r_yrs;
    assign o_base         = r_base;
    assign o_hour         = r_hour;
    assign o_min          = r_min;
    assign o_sec          = r_sec;

    `DTTE_ASSERT_IMPLIES(a_rem_digits, i_clk, i_rst_n, i_ctl.valid,
        i_mday < C_DIG_W'(C_RADIX) && i_month < C_DIG_W'(C_RADIX)
        && i_min < C_DIG_W'(C_RADIX) && i_sec < C_DIG_W'(C_RADIX),
        "remainder digit pair out of range")
    `DTTE_ASSERT_IMPLIES(a_top_digits, i_clk, i_rst_n, i_ctl.valid && !i_ctl.illegal,
        i_year < C_YEAR_W'(C_RADIX * C_RADIX) && i_hour < C_DIG_W'(C_RADIX),
        "year or hour out of range on a legal transaction")

endmodule

`default_nettype wire

@@ hdl/dtte_accum.sv @@
`default_nettype none

module dtte_accum import dtte_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctl                        i_ctl,
    input  logic                        i_out_of_range,
    input  logic signed [C_YRS_W-1:0]   i_yrs,
    input  logic signed [C_BASE_W-1:0]  i_base,
    input  logic [C_DIG_W-1:0]          i_hour,
    input  logic [C_DIG_W-1:0]          i_min,
    input  logic [C_DIG_W-1:0]          i_sec,
    input  logic signed [C_ZONE_W-1:0]  i_zone,
    output logic                        o_done,
    output logic [C_EPOCH_W-1:0]        o_epoch_seconds,
    output logic                        o_input_illegal,
    output logic                        o_fields_out_of_range
);

    // stage d: year days and time of day
    t_ctl                        r_d_ctl;
    logic                        r_d_oor;
    logic signed [C_DAYS_W-1:0]  r_d_yd;
    logic signed [C_BASE_W-1:0]  r_d_base;
    logic signed [C_TODS_W-1:0]  r_d_tods;
    // stage e: total days
    t_ctl                        r_e_ctl;
    logic                        r_e_oor;
    logic signed [C_DAYS_W-1:0]  r_e_days;
    logic signed [C_TODS_W-1:0]  r_e_tods;
    // stage f: days in seconds
    t_ctl                        r_f_ctl;
    logic                        r_f_oor;
    logic signed [C_EPOCH_W-1:0] r_f_dsec;
    logic signed [C_TODS_W-1:0]  r_f_tods;
    // output stage
    logic                        r_done;
    logic [C_EPOCH_W-1:0]        r_epoch;
    logic                        r_illegal;
    logic                        r_oor;

    logic signed [C_HOURZ_W-1:0] w_hour_z;
    logic signed [C_TODS_W-1:0]  n_tods;
    logic signed [C_DAYS_W-1:0]  n_yd;
    logic signed [C_DAYS_W-1:0]  n_days;
    logic signed [C_EPOCH_W-1:0] n_dsec;
    logic signed [C_EPOCH_W-1:0] n_total;

    always_comb begin
        w_hour_z = $signed({1'b0, i_hour}) + C_HOURZ_W'(i_zone);
        n_tods   = C_TODS_W'(w_hour_z) * C_TODS_W'(C_SEC_PER_HOUR)
                 + $signed(C_TODS_W'(i_min) * C_TODS_W'(C_SEC_PER_MIN))
                 + $signed(C_TODS_W'(i_sec));
        n_yd     = C_DAYS_W'(i_yrs) * C_DAYS_W'(C_DAYS_PER_YR);
        n_days   = r_d_yd + C_DAYS_W'(r_d_base);
        n_dsec   = C_EPOCH_W'(r_e_days) * C_EPOCH_W'(C_SEC_PER_DAY);
        n_total  = r_f_dsec + C_EPOCH_W'(r_f_tods);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
            r_e_ctl <= '0;
            r_f_ctl <= '0;
            r_done  <= 1'b0;
        end else begin
            r_d_ctl <= i_ctl;
            r_e_ctl <= r_d_ctl;
            r_f_ctl <= r_e_ctl;
            r_done  <= r_f_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_oor   <= i_out_of_range;
        r_d_yd    <= n_yd;
        r_d_base  <= i_base;
        r_d_tods  <= n_tods;
        r_e_oor   <= r_d_oor;
        r_e_days  <= n_days;
        r_e_tods  <= r_d_tods;
        r_f_oor   <= r_e_oor;
        r_f_dsec  <= n_dsec;
        r_f_tods  <= r_e_tods;
        r_epoch   <= r_f_ctl.illegal ? '0 : n_total;
        r_illegal <= r_f_ctl.illegal;
        r_oor     <= r_f_oor;
    end

    assign o_done                = r_done;
    assign o_epoch_seconds       = r_epoch;
    assign o_input_illegal       = r_illegal;
    assign o_fields_out_of_range = r_oor;

endmodule

`default_nettype wire

@@ hdl/decimal_date_time_to_epoch.sv @@
// Converts a decimal date YYYYMMDD and time HHMMSS into signed seconds since
// 1970-01-01 00:00, shifted by the configured zone offset in hours. The
// pipeline accepts one transaction every clock cycle (o_busy never rises) and
// each result appears on o_done in order; the receiver cannot stall, so
// results must be taken as they come. A result passes through the input
// register, the two digit-pair divider stages (each a registered multiply by
// a reciprocal then a registered correction), one calendar stage and four
// summing stages including the output register. A negative date or time
// gives zero seconds with o_input_illegal set. Write the zone offset only
// while no transaction is in flight.
`default_nettype none
`include "decimal_date_time_to_epoch_macros.svh"

module decimal_date_time_to_epoch import dtte_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [C_ZONE_W-1:0]        i_cfg_wr_data,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic signed [C_DATE_W-1:0] i_date_decimal,
    input  logic signed [C_TIME_W-1:0] i_time_decimal,
    output logic                       o_done,
    output logic signed [C_EPOCH_W-1:0] o_epoch_seconds,
    output logic                       o_input_illegal,
    output logic                       o_fields_out_of_range
);

    localparam int C_ALIGN = 4;
    localparam int C_DELAY = 2;
    localparam int C_LAT   = 10;

    logic signed [C_ZONE_W-1:0] r_zone;

    t_ctl                      r_s1_ctl;
    logic [C_DATE_MAG_W-1:0]   r_s1_date;
    logic [C_TIME_MAG_W-1:0]   r_s1_time;
    t_ctl                      r_ctl_pipe [C_ALIGN];
    logic [C_DIG_W-1:0]        r_mday_d [C_DELAY];
    logic [C_DIG_W-1:0]        r_sec_d [C_DELAY];

    logic [C_DATE_MAG_W-1:0]   w_ymd_q;
    logic [C_DIG_W-1:0]        w_mday;
    logic [C_TIME_MAG_W-1:0]   w_hms_q;
    logic [C_DIG_W-1:0]        w_sec;
    logic [C_YMD_Q_W-1:0]      w_year_q;
    logic [C_DIG_W-1:0]        w_month;
    logic [C_HMS_Q_W-1:0]      w_hour_q;
    logic [C_DIG_W-1:0]        w_min;

    t_ctl                       w_cal_ctl;
    logic                       w_cal_oor;
    logic signed [C_YRS_W-1:0]  w_cal_yrs;
    logic signed [C_BASE_W-1:0] w_cal_base;
    logic [C_DIG_W-1:0]         w_cal_hour;
    logic [C_DIG_W-1:0]         w_cal_min;
    logic [C_DIG_W-1:0]         w_cal_sec;
    logic [C_EPOCH_W-1:0]       w_epoch;

    t_ctl n_s1_ctl;

    assign o_busy = 1'b0;

    always_comb begin
        n_s1_ctl.valid   = i_start;
        n_s1_ctl.illegal = i_date_decimal[C_DATE_W-1] | i_time_decimal[C_TIME_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg_wr_en) begin
            r_zone <= $signed(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            for (int i = 0; i < C_ALIGN; i++) begin
                r_ctl_pipe[i] <= '0;
            end
        end else begin
            r_s1_ctl      <= n_s1_ctl;
            r_ctl_pipe[0] <= r_s1_ctl;
            for (int i = 1; i < C_ALIGN; i++) begin
                r_ctl_pipe[i] <= r_ctl_pipe[i-1];
            end
        end
    end

    // illegal inputs still flow through, the result is forced to zero at the end
    always_ff @(posedge i_clk) begin
        r_s1_date   <= C_DATE_MAG_W'(i_date_decimal);
        r_s1_time   <= C_TIME_MAG_W'(i_time_decimal);
        r_mday_d[0] <= w_mday;
        r_sec_d[0]  <= w_sec;
        for (int i = 1; i < C_DELAY; i++) begin
            r_mday_d[i] <= r_mday_d[i-1];
            r_sec_d[i]  <= r_sec_d[i-1];
        end
    end

    dtte_div100 #(.W(C_DATE_MAG_W)) u_div_day (
        .i_clk  (i_clk),
        .i_x    (r_s1_date),
        .o_quot (w_ymd_q),
        .o_rem  (w_mday)
    );

    dtte_div100 #(.W(C_TIME_MAG_W)) u_div_sec (
        .i_clk  (i_clk),
        .i_x    (r_s1_time),
        .o_quot (w_hms_q),
        .o_rem  (w_sec)
    );

    dtte_div100 #(.W(C_YMD_Q_W)) u_div_month (
        .i_clk  (i_clk),
        .i_x    (w_ymd_q[C_YMD_Q_W-1:0]),
        .o_quot (w_year_q),
        .o_rem  (w_month)
    );

    dtte_div100 #(.W(C_HMS_Q_W)) u_div_min (
        .i_clk  (i_clk),
        .i_x    (w_hms_q[C_HMS_Q_W-1:0]),
        .o_quot (w_hour_q),
        .o_rem  (w_min)
    );

    dtte_cal u_cal (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (r_ctl_pipe[C_ALIGN-1]),
        .i_year         (w_year_q[C_YEAR_W-1:0]),
        .i_month        (w_month),
        .i_mday         (r_mday_d[C_DELAY-1]),
        .i_hour         (w_hour_q[C_DIG_W-1:0]),
        .i_min          (w_min),
        .i_sec          (r_sec_d[C_DELAY-1]),
        .o_ctl          (w_cal_ctl),
        .o_out_of_range (w_cal_oor),
        .o_yrs          (w_cal_yrs),
        .o_base         (w_cal_base),
        .o_hour         (w_cal_hour),
        .o_min          (w_cal_min),
        .o_sec          (w_cal_sec)
    );

    dtte_accum u_accum (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_ctl                 (w_cal_ctl),
        .i_out_of_range        (w_cal_oor),
        .i_yrs                 (w_cal_yrs),
        .i_base                (w_cal_base),
        .i_hour                (w_cal_hour),
        .i_min                 (w_cal_min),
        .i_sec                 (w_cal_sec),
        .i_zone                (r_zone),
        .o_done                (o_done),
        .o_epoch_seconds       (w_epoch),
        .o_input_illegal       (o_input_illegal),
        .o_fields_out_of_range (o_fields_out_of_range)
    );

    assign o_epoch_seconds = $signed(w_epoch);

    `DTTE_ASSERT_IMPLIES(a_latency_hit, i_clk, i_rst_n, i_start && !o_busy,
        ##C_LAT o_done, "accepted transaction did not complete on time")
    `DTTE_ASSERT_IMPLIES(a_latency_none, i_clk, i_rst_n, !i_start,
        ##C_LAT !o_done, "result strobe without an accepted transaction")
    `DTTE_ASSERT_IMPLIES(a_illegal_zero, i_clk, i_rst_n, o_done && o_input_illegal,
        o_epoch_seconds == '0 && !o_fields_out_of_range,
        "illegal transaction returned a value or a range flag")

endmodule

`default_nettype wire

@@ tb/dtte_checker.sv @@
`default_nettype none

module dtte_checker import dtte_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [C_ZONE_W-1:0]         i_cfg_wr_data,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic signed [C_DATE_W-1:0]  i_date_decimal,
    input  logic signed [C_TIME_W-1:0]  i_time_decimal,
    input  logic                        i_done,
    input  logic signed [C_EPOCH_W-1:0] i_epoch_seconds,
    input  logic                        i_input_illegal,
    input  logic                        i_fields_out_of_range,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [C_EPOCH_W-1:0] seconds;
        logic                 illegal;
        logic                 out_of_range;
    } t_epoch_result;

    t_epoch_result              expected_epochs [$];
    logic signed [C_ZONE_W-1:0] zone_hours;

    function automatic longint month_length(input int idx, input bit leap);
        case (idx)
            1:       return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic t_epoch_result predict_epoch(input logic signed [C_DATE_W-1:0] date_dec,
                                                    input logic signed [C_TIME_W-1:0] time_dec,
                                                    input logic signed [C_ZONE_W-1:0] zone);
        longint        d, t, sec, mins, hours, mday, month, year;
        longint        yrs, q, leaps, days, total, nmon;
        bit            leap, bad;
        int            m;
        t_epoch_result r;
        d = longint'(date_dec);
        t = longint'(time_dec);
        r = '0;
        if (d < 0 || t < 0) begin
            r.illegal = 1'b1;
            return r;
        end
        sec   = t % 100;
        mins  = (t / 100) % 100;
        hours = t / 10000;
        mday  = d % 100;
        month = (d / 100) % 100;
        year  = d / 10000;
        bad   = (sec > 60) || (mins >= 60) || (hours >= 24) || (month > 12);

        // every fourth year from 1972, floor division so years before 1970 work too
        yrs   = year - 1970;
        q     = yrs + 2;
        leaps = (q >= 0) ? q / 4 : -((-q + 3) / 4);
        leap  = (q - 4 * leaps) == 0;

        nmon = month - 1;
        if (nmon > 12) begin
            nmon = 12;
        end
        days = 0;
        for (m = 0; m < nmon; m++) begin
            days += month_length(m, leap);
        end
        // the current year's leap day is covered by the month table
        if (leap) begin
            leaps -= 1;
        end
        days += mday - 1;
        days += yrs * 365 + leaps;

        total = days * 86400 + (hours + longint'(zone)) * 3600 + mins * 60 + sec;
        r.seconds      = total[C_EPOCH_W-1:0];
        r.out_of_range = bad;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_epoch_result want;
        if (!i_rst_n) begin
            zone_hours <= '0;
            expected_epochs.delete();
            o_fail_count = 0;
        end else begin
            if (i_done) begin
                if (expected_epochs.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: result with no transaction pending: sec=%0d ill=%b oor=%b",
                                 $realtime, i_epoch_seconds, i_input_illegal,
                                 i_fields_out_of_range);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_epochs.pop_front();
                    if (i_epoch_seconds !== want.seconds || i_input_illegal !== want.illegal ||
                        i_fields_out_of_range !== want.out_of_range) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: exp sec=%0d ill=%b oor=%b got sec=%0d ill=%b oor=%b",
                                     $realtime, $signed(want.seconds), want.illegal,
                                     want.out_of_range, i_epoch_seconds, i_input_illegal,
                                     i_fields_out_of_range);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_epochs.push_back(predict_epoch(i_date_decimal, i_time_decimal,
                                                        zone_hours));
            end
            if (i_cfg_wr_en) begin
                zone_hours <= i_cfg_wr_data;
            end
        end
        o_pending = expected_epochs.size();
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb import dtte_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [C_ZONE_W-1:0]         cfg_wr_data;
    logic                        start;
    logic                        busy;
    logic signed [C_DATE_W-1:0]  date_dec;
    logic signed [C_TIME_W-1:0]  time_dec;
    logic                        done;
    logic signed [C_EPOCH_W-1:0] epoch_seconds;
    logic                        input_illegal;
    logic                        fields_out_of_range;
    int                          fail_count;
    int                          pending;

    decimal_date_time_to_epoch uut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_wr_en           (cfg_wr_en),
        .i_cfg_wr_data         (cfg_wr_data),
        .i_start               (start),
        .o_busy                (busy),
        .i_date_decimal        (date_dec),
        .i_time_decimal        (time_dec),
        .o_done                (done),
        .o_epoch_seconds       (epoch_seconds),
        .o_input_illegal       (input_illegal),
        .o_fields_out_of_range (fields_out_of_range)
    );

    dtte_checker epoch_check (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_wr_en           (cfg_wr_en),
        .i_cfg_wr_data         (cfg_wr_data),
        .i_start               (start),
        .i_busy                (busy),
        .i_date_decimal        (date_dec),
        .i_time_decimal        (time_dec),
        .i_done                (done),
        .i_epoch_seconds       (epoch_seconds),
        .i_input_illegal       (input_illegal),
        .i_fields_out_of_range (fields_out_of_range),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_item(input int date_v, input int time_v, input bit idle_on);
        while (idle_on && $urandom_range(99) < 17) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        date_dec <= C_DATE_W'(date_v);
        time_dec <= C_TIME_W'(time_v);
        while (busy) begin
            @(negedge clk);
        end
        @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_zone(input int hours);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= C_ZONE_W'(hours);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic make_item(output int date_v, output int time_v);
        int kind;
        int year, month, day, hh, mm, ss;
        kind = $urandom_range(99);
        if (kind < 70) begin
            year   = ($urandom_range(4) != 0) ? $urandom_range(2099, 1901) : $urandom_range(9999);
            month  = $urandom_range(12, 1);
            day    = $urandom_range(31, 1);
            hh     = $urandom_range(23);
            mm     = $urandom_range(59);
            ss     = $urandom_range(60);
            date_v = year * 10000 + month * 100 + day;
            time_v = hh * 10000 + mm * 100 + ss;
        end else if (kind < 85) begin
            year   = $urandom_range(9999);
            month  = $urandom_range(99);
            day    = $urandom_range(99);
            hh     = $urandom_range(99);
            mm     = $urandom_range(99);
            ss     = $urandom_range(99);
            date_v = year * 10000 + month * 100 + day;
            time_v = hh * 10000 + mm * 100 + ss;
        end else if (kind < 95) begin
            date_v = $urandom_range(99999999);
            time_v = $urandom_range(999999);
        end else begin
            date_v = $urandom_range(99999999);
            time_v = $urandom_range(999999);
            case ($urandom_range(2))
                0: date_v = -int'($urandom_range(99999999, 1));
                1: time_v = -int'($urandom_range(999999, 1));
                default: begin
                    date_v = -int'($urandom_range(99999999, 1));
                    time_v = -int'($urandom_range(999999, 1));
                end
            endcase
        end
    endtask

    initial begin
        int dir_dates [25] = '{
            19700101, 19691231, 20000229, 20240001, 20240300, 20241301, 20249999,
            20240101, 20240101, 20240101, 20240101, 20240101, 0, 99999999,
            99991231, 19010101, 20991231, 21000301, -99999999, 20240101, -1,
            19000101, -1, 101, 19680229
        };
        int dir_times [25] = '{
            0, 235959, 235959, 120000, 0, 0, 0,
            60, 61, 6000, 240000, 999999, 0, 999999,
            235959, 0, 235959, 0, 0, -999999, -1,
            0, 120000, 0, 120000
        };
        int phase_zone [6] = '{-12, 14, -1, 0, 0, 0};
        int date_v, time_v;
        int p, n;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        start       = 1'b0;
        date_dec    = '0;
        time_dec    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_zone(0);
        for (n = 0; n < 25; n++) begin
            send_item(dir_dates[n], dir_times[n], 1'b1);
        end
        drain();

        phase_zone[3] = int'($urandom_range(26)) - 12;
        phase_zone[4] = int'($urandom_range(26)) - 12;
        for (p = 0; p < 6; p++) begin
            write_zone(phase_zone[p]);
            for (n = 0; n < 255; n++) begin
                make_item(date_v, time_v);
                // back-to-back transactions for the whole of one phase
                send_item(date_v, time_v, p != 1);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
